@@ rtl/core/byte_ring_buffer_unit_defines.svh @@
// ---------------------------------------------------------------------------
// byte_ring_buffer_unit_defines.svh
// Assertion macros shared by the byte ring buffer checkers.
// ---------------------------------------------------------------------------
`ifndef BYTE_RING_BUFFER_UNIT_DEFINES_SVH
`define BYTE_RING_BUFFER_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while in reset
`define BRB_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while in reset
`define BRB_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/core/brb_pkg.sv @@
// ---------------------------------------------------------------------------
// brb_pkg
// Types and codes shared by the byte ring buffer modules.
// ---------------------------------------------------------------------------
package brb_pkg;

    // Request kinds
    localparam logic [1:0] REQ_PUSH = 2'd0;
    localparam logic [1:0] REQ_POP  = 2'd1;
    localparam logic [1:0] REQ_PEEK = 2'd2;

    // Response status codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_DROPPED = 2'd1;
    localparam logic [1:0] ST_CLEARED = 2'd2;
    localparam logic [1:0] ST_EMPTY   = 2'd3;

    // Register indexes
    localparam logic REG_CAPACITY = 1'b0;
    localparam logic REG_CLEAR    = 1'b1;

    localparam int CAP_W   = 9;
    localparam int PADDR_W = 3;

    // Request word
    typedef struct packed {
        logic [1:0] req_type;
        logic [7:0] write_data;
        logic [7:0] peek_offset;
    } brb_req_t;

    // Response word
    typedef struct packed {
        logic [1:0] status;
        logic [7:0] read_data;
        logic [7:0] occupancy;
    } brb_rsp_t;

    // Configuration seen by the ring control
    typedef struct packed {
        logic [CAP_W-1:0] capacity;
        logic             clear_on_full;
        logic             cap_write;
    } brb_cfg_t;

    // Per-request result carried down the pipe beside the RAM read
    typedef struct packed {
        logic [1:0] status;
        logic [7:0] occupancy;
        logic       is_read;
    } brb_info_t;

endpackage

@@ rtl/core/brb_cfg_regs.sv @@
// ---------------------------------------------------------------------------
// brb_cfg_regs
// APB register file: ring capacity and full-push policy.
// ---------------------------------------------------------------------------
module brb_cfg_regs
    import brb_pkg::*;
#(
    parameter int CAP_RESET = 256
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    output brb_cfg_t           cfg
);

    logic [CAP_W-1:0] capacity_reg;
    logic             clear_reg;
    logic             wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    // Register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg <= CAP_W'(CAP_RESET);
            clear_reg    <= 1'b0;
        end
        else if (wr_en)
        begin
            if (paddr[2] == REG_CAPACITY)
                capacity_reg <= pwdata[CAP_W-1:0];
            else
                clear_reg <= pwdata[0];
        end
    end

    // Read mux
    always_comb
    begin
        if (paddr[2] == REG_CLEAR)
            prdata = {31'd0, clear_reg};
        else
            prdata = {{(32-CAP_W){1'b0}}, capacity_reg};
    end

    assign cfg.capacity      = capacity_reg;
    assign cfg.clear_on_full = clear_reg;
    assign cfg.cap_write     = wr_en && (paddr[2] == REG_CAPACITY);

endmodule

@@ rtl/core/brb_ram.sv @@
// ---------------------------------------------------------------------------
// brb_ram
// Byte store: one write port, one read port with registered read data.
// ---------------------------------------------------------------------------
module brb_ram
#(
    parameter int DEPTH = 256,
    parameter int AW    = 8
)
(
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [7:0]    wdata,
    input  logic          re,
    input  logic [AW-1:0] raddr,
    output logic [7:0]    rdata
);

    logic [7:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
    end

    // Read port, held while no read is issued
    always_ff @(posedge clk)
    begin
        if (re)
            rdata <= mem[raddr];
    end

endmodule

@@ rtl/core/brb_ring_ctrl.sv @@
// ---------------------------------------------------------------------------
// brb_ring_ctrl
// Head/tail pointers, request decode and RAM access generation.
// ---------------------------------------------------------------------------
module brb_ring_ctrl
    import brb_pkg::*;
#(
    parameter int MAX_SLOTS = 256,
    parameter int IDX_W     = 8,
    parameter int CW        = 9
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  brb_cfg_t         cfg,
    input  logic             accept,
    input  brb_req_t         req,
    output logic             mem_we,
    output logic [IDX_W-1:0] mem_waddr,
    output logic             mem_re,
    output logic [IDX_W-1:0] mem_raddr,
    output brb_info_t        info
);

    // peek sum width: index plus 8-bit offset, one carry bit
    localparam int SW = ((CW > 8) ? CW : 8) + 1;

    logic [IDX_W-1:0] head_reg, head_next;
    logic [IDX_W-1:0] tail_reg, tail_next;
    logic [CW-1:0]    size;
    logic [CW-1:0]    head_w, tail_w;
    logic [CW-1:0]    head_inc, tail_inc;
    logic [CW-1:0]    count, count_after;
    logic             full, empty, peek_hit;
    logic [SW-1:0]    peek_sum;
    logic [SW-1:0]    peek_addr;

    // Clamp the programmed capacity into the supported range
    always_comb
    begin
        if (32'(cfg.capacity) < 32'd2)
            size = CW'(2);
        else if (32'(cfg.capacity) > 32'(MAX_SLOTS))
            size = CW'(MAX_SLOTS);
        else
            size = CW'(cfg.capacity);
    end

    assign head_w = CW'(head_reg);
    assign tail_w = CW'(tail_reg);

    // Stored count and wrap-around increments
    assign count    = (tail_w >= head_w) ? (tail_w - head_w) : (tail_w + size - head_w);
    assign full     = (count == size - CW'(1));
    assign empty    = (count == '0);
    assign head_inc = (head_w + CW'(1) == size) ? '0 : head_w + CW'(1);
    assign tail_inc = (tail_w + CW'(1) == size) ? '0 : tail_w + CW'(1);

    // Peek address: head + offset stays below twice the size when in range
    assign peek_hit  = 32'(req.peek_offset) < 32'(count);
    assign peek_sum  = SW'(head_w) + SW'(req.peek_offset);
    assign peek_addr = (peek_sum >= SW'(size)) ? peek_sum - SW'(size) : peek_sum;

    assign mem_waddr = tail_reg;

    // Request decode
    always_comb
    begin
        head_next    = head_reg;
        tail_next    = tail_reg;
        mem_we       = 1'b0;
        mem_re       = 1'b0;
        mem_raddr    = head_reg;
        info.status  = ST_OK;
        info.is_read = 1'b0;
        count_after  = count;
        case (req.req_type)
            REQ_PUSH:
            begin
                if (full)
                begin
                    if (cfg.clear_on_full)
                    begin
                        head_next   = '0;
                        tail_next   = '0;
                        count_after = '0;
                        info.status = ST_CLEARED;
                    end
                    else
                        info.status = ST_DROPPED;
                end
                else
                begin
                    mem_we      = accept;
                    tail_next   = IDX_W'(tail_inc);
                    count_after = count + CW'(1);
                end
            end
            REQ_POP:
            begin
                if (empty)
                    info.status = ST_EMPTY;
                else
                begin
                    mem_re       = accept;
                    info.is_read = 1'b1;
                    head_next    = IDX_W'(head_inc);
                    count_after  = count - CW'(1);
                end
            end
            REQ_PEEK:
            begin
                if (peek_hit)
                begin
                    mem_re       = accept;
                    mem_raddr    = IDX_W'(peek_addr);
                    info.is_read = 1'b1;
                end
                else
                    info.status = ST_EMPTY;
            end
            default:
            begin
                // unknown kind: no change, ok status
            end
        endcase
        info.occupancy = (32'(count_after) > 32'd255) ? 8'hFF : 8'(count_after);
    end

    // Pointer registers; a capacity write empties the ring
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg <= '0;
            tail_reg <= '0;
        end
        else if (cfg.cap_write)
        begin
            head_reg <= '0;
            tail_reg <= '0;
        end
        else if (accept)
        begin
            head_reg <= head_next;
            tail_reg <= tail_next;
        end
    end

endmodule

@@ rtl/core/byte_ring_buffer_unit.sv @@
// ---------------------------------------------------------------------------
// byte_ring_buffer_unit
// Byte ring buffer with push, pop and peek requests and an APB config port.
// ---------------------------------------------------------------------------
//  channel   | direction | handshake            | word
//  ----------+-----------+----------------------+-----------------------------
//  req       | in        | req_valid/req_ready  | req_type, write_data, peek_offset
//  rsp       | out       | rsp_valid/rsp_ready  | status, read_data, occupancy
//  apb       | in        | psel/penable/pready  | paddr, pwdata, prdata
//
//  One request per clock while req_ready is high; each accepted word's
//  response passes the RAM read register, then the output register.
//  Pointers update at accept, so back-to-back requests see prior effects.
//  A stalled rsp holds; one more result waits in the RAM stage before
//  req_ready drops.
//  Reset empties the ring; the byte store itself is not cleared.
// ---------------------------------------------------------------------------
module byte_ring_buffer_unit
    import brb_pkg::*;
#(
    parameter int MAX_SLOTS = 256
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_ready,
    input  brb_req_t           req,
    output logic               rsp_valid,
    input  logic               rsp_ready,
    output brb_rsp_t           rsp,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    localparam int IDX_W     = (MAX_SLOTS > 2) ? $clog2(MAX_SLOTS) : 1;
    localparam int CW        = $clog2(MAX_SLOTS + 1);
    localparam int CAP_RESET = (MAX_SLOTS > 511) ? 511 : MAX_SLOTS;

    brb_cfg_t         cfg;
    brb_info_t        info;
    brb_info_t        s1_info_reg;
    logic             s1_valid_reg;
    logic             out_valid_reg;
    brb_rsp_t         out_rsp_reg;
    logic             in_accept;
    logic             s1_adv;
    logic             mem_we, mem_re;
    logic [IDX_W-1:0] mem_waddr, mem_raddr;
    logic [7:0]       mem_rdata;

    brb_cfg_regs #(
        .CAP_RESET (CAP_RESET)
    ) u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    brb_ring_ctrl #(
        .MAX_SLOTS (MAX_SLOTS),
        .IDX_W     (IDX_W),
        .CW        (CW)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .accept    (in_accept),
        .req       (req),
        .mem_we    (mem_we),
        .mem_waddr (mem_waddr),
        .mem_re    (mem_re),
        .mem_raddr (mem_raddr),
        .info      (info)
    );

    brb_ram #(
        .DEPTH (MAX_SLOTS),
        .AW    (IDX_W)
    ) u_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (req.write_data),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // Pipe control
    assign s1_adv    = s1_valid_reg && (!out_valid_reg || rsp_ready);
    assign req_ready = !s1_valid_reg || s1_adv;
    assign in_accept = req_valid && req_ready;

    // RAM stage: side info beside the registered read data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (in_accept)
            s1_valid_reg <= 1'b1;
        else if (s1_adv)
            s1_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
            s1_info_reg <= info;
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (s1_adv)
            out_valid_reg <= 1'b1;
        else if (rsp_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv)
        begin
            out_rsp_reg.status    <= s1_info_reg.status;
            out_rsp_reg.occupancy <= s1_info_reg.occupancy;
            out_rsp_reg.read_data <= s1_info_reg.is_read ? mem_rdata : 8'd0;
        end
    end

    assign rsp_valid = out_valid_reg;
    assign rsp       = out_rsp_reg;

endmodule

@@ rtl/core/brb_checker.sv @@
// ---------------------------------------------------------------------------
// brb_checker
// Port-level assertions for the byte ring buffer, bound to the top level.
// ---------------------------------------------------------------------------
`include "byte_ring_buffer_unit_defines.svh"

module brb_checker
    import brb_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               req_valid,
    input logic               req_ready,
    input logic               rsp_valid,
    input logic               rsp_ready,
    input brb_rsp_t           rsp
);

    // A stalled response word holds
    `BRB_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp), "rsp changed while stalled")

    // Only a successful pop or peek carries data
    `BRB_ASSERT_NOW(a_data_zero, rsp_valid && (rsp.status != ST_OK), rsp.read_data == 8'd0, "data on a failed request")

    // A clearing push leaves the ring empty
    `BRB_ASSERT_NOW(a_clear_empty, rsp_valid && (rsp.status == ST_CLEARED), rsp.occupancy == 8'd0, "clear left bytes")

    // Two words of buffering: with rsp stalled and a word already waiting, intake stops
    `BRB_ASSERT_NEXT(a_backpressure, rsp_valid && !rsp_ready && req_valid && req_ready, !rsp_ready |-> !req_ready || !rsp_valid, "intake overran stalled output")

endmodule

bind byte_ring_buffer_unit brb_checker u_brb_checker (.*);

@@ tb/tb_byte_ring_buffer_unit.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_byte_ring_buffer_unit
// Self-checking bench for the byte ring buffer: a directed list of pushes,
// pops, peeks and register writes, then random request streams over several
// ring sizes and full policies. Each accepted request word runs through a
// local model of the ring, and every response word is compared in order.
// ---------------------------------------------------------------------------
module tb_byte_ring_buffer_unit;
    import brb_pkg::*;

    localparam int RING_SLOTS     = 256;
    localparam int IDLE_PCT       = 11;
    localparam int HOLD_CYCLES    = 60;
    localparam int DRAIN_CYCLES   = 4;
    localparam int WATCHDOG_LIMIT = 2000;

    localparam logic [1:0]         REQ_UNKNOWN   = 2'd3;
    localparam logic [PADDR_W-1:0] ADDR_CAPACITY = {REG_CAPACITY, 2'b00};
    localparam logic [PADDR_W-1:0] ADDR_CLEAR    = {REG_CLEAR, 2'b00};

    // One step of the directed list: either a register write or a request
    typedef struct {
        bit                 is_cfg;
        logic [PADDR_W-1:0] addr;
        logic [31:0]        data;
        brb_req_t           word;
        bit                 fixed;
        brb_rsp_t           want;
    } dir_row_t;

    logic               clk;
    logic               rst_n;
    logic               req_valid;
    logic               req_ready;
    brb_req_t           req;
    logic               rsp_valid;
    logic               rsp_ready;
    brb_rsp_t           rsp;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [31:0]        pwdata;
    logic [31:0]        prdata;
    logic               pready;

    // Ring model state
    logic [7:0]       ring_mem [RING_SLOTS];
    int               rd_ptr;
    int               wr_ptr;
    logic [CAP_W-1:0] cap_reg;
    logic             clear_reg;

    brb_rsp_t rsp_expect_q [$];
    dir_row_t dir_rows [$];
    brb_rsp_t predicted_rsp;
    brb_rsp_t oldest_rsp;
    bit       word_has_fixed;
    brb_rsp_t word_fixed_rsp;
    bit       src_gaps_on  = 1'b1;
    bit       sink_gaps_on = 1'b1;
    bit       hold_off_req = 1'b0;
    int       err_count    = 0;
    int       stall_cycles = 0;

    byte_ring_buffer_unit #(
        .MAX_SLOTS (RING_SLOTS)
    ) DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Slots in use, with out-of-range capacity clamped
    function automatic int ring_size();
        if (cap_reg < 2)
            return 2;
        if (cap_reg > RING_SLOTS)
            return RING_SLOTS;
        return int'(cap_reg);
    endfunction

    function automatic int ring_count();
        int s;
        s = ring_size();
        return (wr_ptr + s - rd_ptr) % s;
    endfunction

    // Apply one request to the ring model and return its response word
    function automatic brb_rsp_t ring_predict(brb_req_t w);
        brb_rsp_t o;
        int       s;
        int       n;
        s      = ring_size();
        rd_ptr = rd_ptr % s;
        wr_ptr = wr_ptr % s;
        n      = ring_count();
        o      = '0;
        case (w.req_type)
            REQ_PUSH:
            begin
                if ((wr_ptr + 1) % s == rd_ptr)
                begin
                    if (clear_reg)
                    begin
                        rd_ptr   = 0;
                        wr_ptr   = 0;
                        o.status = ST_CLEARED;
                    end
                    else
                    begin
                        o.status = ST_DROPPED;
                    end
                end
                else
                begin
                    ring_mem[wr_ptr] = w.write_data;
                    wr_ptr           = (wr_ptr + 1) % s;
                end
            end
            REQ_POP:
            begin
                if (n == 0)
                begin
                    o.status = ST_EMPTY;
                end
                else
                begin
                    o.read_data = ring_mem[rd_ptr];
                    rd_ptr      = (rd_ptr + 1) % s;
                end
            end
            REQ_PEEK:
            begin
                if (w.peek_offset >= n)
                    o.status = ST_EMPTY;
                else
                    o.read_data = ring_mem[(rd_ptr + w.peek_offset) % s];
            end
            default:
            begin
            end
        endcase
        n           = ring_count();
        o.occupancy = (n > 255) ? 8'd255 : n[7:0];
        return o;
    endfunction

    // Random request; peek offsets lean toward the stored range
    function automatic brb_req_t pick_req(int push_pct);
        brb_req_t w;
        int       k;
        int       n;
        w.write_data = 8'($urandom_range(0, 255));
        k = $urandom_range(99);
        if (k < push_pct)
        begin
            w.req_type = REQ_PUSH;
        end
        else
        begin
            k = $urandom_range(99);
            if (k < 3)
                w.req_type = REQ_UNKNOWN;
            else if (k < 50)
                w.req_type = REQ_POP;
            else
                w.req_type = REQ_PEEK;
        end
        n = ring_count();
        k = $urandom_range(99);
        if (k < 60)
            w.peek_offset = 8'($urandom_range(0, n));
        else if (k < 85)
            w.peek_offset = 8'($urandom_range(0, 3));
        else
            w.peek_offset = 8'($urandom_range(0, 255));
        return w;
    endfunction

    // Directed list builders
    task automatic add_cfg(input logic [PADDR_W-1:0] a, input logic [31:0] d);
        dir_row_t r;
        r        = '{default: '0};
        r.is_cfg = 1'b1;
        r.addr   = a;
        r.data   = d;
        dir_rows.push_back(r);
    endtask

    task automatic add_req(input logic [1:0] t, input logic [7:0] wd, input logic [7:0] off);
        dir_row_t r;
        r      = '{default: '0};
        r.word = '{req_type: t, write_data: wd, peek_offset: off};
        dir_rows.push_back(r);
    endtask

    task automatic add_chk(input logic [1:0] t, input logic [7:0] wd, input logic [7:0] off,
                           input logic [1:0] st, input logic [7:0] rd, input logic [7:0] occ);
        dir_row_t r;
        r       = '{default: '0};
        r.word  = '{req_type: t, write_data: wd, peek_offset: off};
        r.fixed = 1'b1;
        r.want  = '{status: st, read_data: rd, occupancy: occ};
        dir_rows.push_back(r);
    endtask

    // Offer one request word and hold it until accepted
    task automatic send_req(input brb_req_t w, input bit fixed, input brb_rsp_t want);
        @(negedge clk);
        while (src_gaps_on && $urandom_range(99) < IDLE_PCT)
        begin
            req_valid = 1'b0;
            @(negedge clk);
        end
        req            = w;
        word_has_fixed = fixed;
        word_fixed_rsp = want;
        req_valid      = 1'b1;
        @(posedge clk);
        while (!req_ready)
            @(posedge clk);
    endtask

    // Stop offering and wait until every response word has come back
    task automatic settle();
        @(negedge clk);
        req_valid = 1'b0;
        while (rsp_expect_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // APB write: setup then access; the model follows at the write edge
    task automatic apb_write(input logic [PADDR_W-1:0] a, input logic [31:0] d);
        @(negedge clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = a;
        pwdata  = d;
        @(negedge clk);
        penable = 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        if (a == ADDR_CAPACITY)
        begin
            cap_reg = d[CAP_W-1:0];
            rd_ptr  = 0;
            wr_ptr  = 0;
        end
        else if (a == ADDR_CLEAR)
        begin
            clear_reg = d[0];
        end
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    // Quiet the ring, apply settings (negative means leave as is), then stream
    task automatic run_phase(input int cap_val, input int clr_val, input int n_items,
                             input int push_pct, input bit squeeze);
        settle();
        if (cap_val >= 0)
            apb_write(ADDR_CAPACITY, cap_val);
        if (clr_val >= 0)
            apb_write(ADDR_CLEAR, clr_val);
        if (squeeze)
            hold_off_req = 1'b1;
        repeat (n_items) send_req(pick_req(push_pct), 1'b0, '0);
    endtask

    task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            err_count++;
        end
    endtask

    // Response side readiness, with an occasional long hold-off
    initial
    begin
        rsp_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_off_req)
            begin
                hold_off_req = 1'b0;
                rsp_ready    = 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
            end
            rsp_ready = !sink_gaps_on || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // Predict on every accepted request word
    always @(posedge clk)
    begin
        if (rst_n && req_valid && req_ready)
        begin
            predicted_rsp = ring_predict(req);
            rsp_expect_q.push_back(word_has_fixed ? word_fixed_rsp : predicted_rsp);
        end
    end

    // Compare every accepted response word with the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && rsp_ready)
        begin
            if (rsp_expect_q.size() == 0)
            begin
                $display("%0t: unexpected response word, status %0h data %0h occupancy %0h",
                         $time, rsp.status, rsp.read_data, rsp.occupancy);
                err_count++;
            end
            else
            begin
                oldest_rsp = rsp_expect_q.pop_front();
                check_field("status", 8'(oldest_rsp.status), 8'(rsp.status));
                check_field("read_data", oldest_rsp.read_data, rsp.read_data);
                check_field("occupancy", oldest_rsp.occupancy, rsp.occupancy);
            end
        end
    end

    // Watchdog: cycles with no transfer on any port
    always @(posedge clk)
    begin
        if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (psel && penable && pready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    // Main sequence
    initial
    begin
        req_valid      = 1'b0;
        req            = '0;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;
        word_has_fixed = 1'b0;
        word_fixed_rsp = '0;
        cap_reg        = CAP_W'(RING_SLOTS);
        clear_reg      = 1'b0;
        rd_ptr         = 0;
        wr_ptr         = 0;
        foreach (ring_mem[i])
            ring_mem[i] = 8'h00;
        rst_n = 1'b0;

        // Reset settings: full size ring, drop on full
        add_chk(REQ_POP,     8'h00, 8'h00, ST_EMPTY, 8'h00, 8'd0);
        add_chk(REQ_PEEK,    8'h00, 8'h00, ST_EMPTY, 8'h00, 8'd0);
        add_chk(REQ_PUSH,    8'hFF, 8'h00, ST_OK,    8'h00, 8'd1);
        add_chk(REQ_PUSH,    8'h00, 8'hFF, ST_OK,    8'h00, 8'd2);
        add_chk(REQ_PEEK,    8'h00, 8'h00, ST_OK,    8'hFF, 8'd2);
        add_chk(REQ_PEEK,    8'hFF, 8'h01, ST_OK,    8'h00, 8'd2);
        add_chk(REQ_PEEK,    8'h00, 8'h02, ST_EMPTY, 8'h00, 8'd2);
        add_chk(REQ_PEEK,    8'h00, 8'hFF, ST_EMPTY, 8'h00, 8'd2);
        add_chk(REQ_UNKNOWN, 8'hFF, 8'hFF, ST_OK,    8'h00, 8'd2);
        add_chk(REQ_POP,     8'h00, 8'h00, ST_OK,    8'hFF, 8'd1);
        add_chk(REQ_POP,     8'hFF, 8'hFF, ST_OK,    8'h00, 8'd0);
        add_chk(REQ_POP,     8'h00, 8'h00, ST_EMPTY, 8'h00, 8'd0);
        // Capacity below range acts as two slots, one usable
        add_cfg(ADDR_CAPACITY, 32'd0);
        add_chk(REQ_PUSH,    8'h81, 8'h00, ST_OK,      8'h00, 8'd1);
        add_chk(REQ_PUSH,    8'h7E, 8'h00, ST_DROPPED, 8'h00, 8'd1);
        add_chk(REQ_PEEK,    8'h00, 8'h00, ST_OK,      8'h81, 8'd1);
        add_chk(REQ_PEEK,    8'h00, 8'h01, ST_EMPTY,   8'h00, 8'd1);
        // Full push with clearing policy
        add_cfg(ADDR_CLEAR, 32'd1);
        add_chk(REQ_PUSH,    8'h3C, 8'h00, ST_CLEARED, 8'h00, 8'd0);
        add_chk(REQ_PEEK,    8'h00, 8'h00, ST_EMPTY,   8'h00, 8'd0);
        add_cfg(ADDR_CAPACITY, 32'd3);
        add_chk(REQ_PUSH,    8'h44, 8'h00, ST_OK,      8'h00, 8'd1);
        add_chk(REQ_PUSH,    8'h55, 8'h00, ST_OK,      8'h00, 8'd2);
        add_chk(REQ_PUSH,    8'h66, 8'h00, ST_CLEARED, 8'h00, 8'd0);
        // Capacity above range, then a capacity write empties the ring
        add_cfg(ADDR_CAPACITY, 32'd511);
        add_cfg(ADDR_CLEAR, 32'd0);
        add_req(REQ_PUSH,    8'hAA, 8'h00);
        add_chk(REQ_POP,     8'h00, 8'h00, ST_OK,      8'hAA, 8'd0);
        add_req(REQ_PUSH,    8'h01, 8'h00);
        add_cfg(ADDR_CAPACITY, 32'd1);
        add_chk(REQ_POP,     8'h00, 8'h00, ST_EMPTY,   8'h00, 8'd0);

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (dir_rows[i])
        begin
            if (dir_rows[i].is_cfg)
            begin
                settle();
                apb_write(dir_rows[i].addr, dir_rows[i].data);
            end
            else
            begin
                send_req(dir_rows[i].word, dir_rows[i].fixed, dir_rows[i].want);
            end
        end

        // Fill the full size ring, the first stretch with no idling at all
        src_gaps_on  = 1'b0;
        sink_gaps_on = 1'b0;
        run_phase(RING_SLOTS, 0, 120, 97, 1'b0);
        src_gaps_on  = 1'b1;
        sink_gaps_on = 1'b1;
        run_phase(-1, -1, 170, 97, 1'b0);
        // Ring left full; switch to clearing without touching capacity
        run_phase(-1, 1, 15, 80, 1'b0);
        run_phase(2, 0, 20, 50, 1'b0);
        run_phase(1, 1, 20, 55, 1'b0);
        // Long response hold-off while requests keep coming
        run_phase(5, 0, 25, 60, 1'b1);
        run_phase(257, 1, 20, 60, 1'b0);
        run_phase($urandom_range(3, 12), $urandom_range(0, 1), 12, 60, 1'b0);
        // Sender pauses until the ring has answered everything
        run_phase(-1, -1, 13, 50, 1'b0);
        run_phase(511, 0, 20, 45, 1'b0);

        settle();
        repeat (10) @(posedge clk);
        if (err_count == 0 && rsp_expect_q.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
